FILE: rtl/lspt_pkg.sv
package lspt_pkg;

  localparam int RANGE_BITS  = 16;
  localparam int ANGLE_BITS  = 16;
  localparam int COORD_BITS  = 18;

  localparam int CFG_DATA_W  = 48;
  localparam int CFG_INDEX_W = 3;
  localparam int OFFSET_W    = 16;
  localparam int COEF_W      = 16;

  // Q15 millimetre coordinate: range times a Q1.15 factor, with headroom for rotation.
  localparam int CW     = RANGE_BITS + 18;
  localparam int PROD_W = CW + COEF_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int FW     = ((CW > COORD_BITS) ? CW : COORD_BITS) + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_FLOOR   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_CEILING = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_START   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_STEP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_YAW_ANGLE     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ROLL_ANGLE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PITCH_ANGLE   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_XYZ    = 3'd7;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range_floor;
    logic [RANGE_BITS-1:0] range_ceiling;
    logic [ANGLE_BITS-1:0] angle_start;
    logic [ANGLE_BITS-1:0] angle_step;
    logic [ANGLE_BITS-1:0] yaw_angle;
    logic [ANGLE_BITS-1:0] roll_angle;
    logic [ANGLE_BITS-1:0] pitch_angle;
    logic [CFG_DATA_W-1:0] offset_xyz;
  } cfg_t;

  typedef struct packed {
    logic [RANGE_BITS-1:0] range;
    logic [ANGLE_BITS-1:0] angle;
  } item_t;

  function automatic logic [31:0] angle_phase(input logic [ANGLE_BITS-1:0] a);
    angle_phase = {a, {(32 - ANGLE_BITS){1'b0}}};
  endfunction

  // Round a Q30 sum back to Q15: add one half, then floor shift.
  function automatic logic signed [ACC_W-1:0] round_q15(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] w;
    w = v + $signed(ACC_W'(16384));
    round_q15 = w >>> 15;
  endfunction

endpackage

FILE: rtl/lspt_front.sv
module lspt_front
  import lspt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [RANGE_BITS-1:0]  range_mm,
  input  logic                   scan_start,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   q_full,
  output cfg_t                   cfg,
  output logic                   q_push,
  output item_t                  q_item
);

  logic [ANGLE_BITS-1:0] beam_angle;
  logic [ANGLE_BITS-1:0] beam_angle_next;
  logic                  accept;
  logic                  in_range;

  assign accept          = push && !q_full;
  assign beam_angle_next = scan_start ? cfg.angle_start : beam_angle + cfg.angle_step;
  assign in_range        = (range_mm >= cfg.range_floor) && (range_mm <= cfg.range_ceiling);
  assign q_push          = accept && in_range;
  assign q_item.range    = range_mm;
  assign q_item.angle    = beam_angle_next;

  // The beam angle advances on every accepted word, rejected or not.
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_angle <= '0;
    end else if (accept) begin
      beam_angle <= beam_angle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{range_ceiling: {RANGE_BITS{1'b1}}, default: '0};
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RANGE_FLOOR:   cfg.range_floor   <= cfg_data[RANGE_BITS-1:0];
        REG_RANGE_CEILING: cfg.range_ceiling <= cfg_data[RANGE_BITS-1:0];
        REG_ANGLE_START:   cfg.angle_start   <= cfg_data[ANGLE_BITS-1:0];
        REG_ANGLE_STEP:    cfg.angle_step    <= cfg_data[ANGLE_BITS-1:0];
        REG_YAW_ANGLE:     cfg.yaw_angle     <= cfg_data[ANGLE_BITS-1:0];
        REG_ROLL_ANGLE:    cfg.roll_angle    <= cfg_data[ANGLE_BITS-1:0];
        REG_PITCH_ANGLE:   cfg.pitch_angle   <= cfg_data[ANGLE_BITS-1:0];
        REG_OFFSET_XYZ:    cfg.offset_xyz    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/lspt_queue.sv
module lspt_queue
  import lspt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd,
  output logic  valid,
  output item_t rd_item
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign rd_item = slots[rd_ptr];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/lspt_sine.sv
module lspt_sine
  import lspt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [31:0]              phase,
  output logic                     done,
  output logic signed [COEF_W-1:0] value
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_P1   = 3'd2;
  localparam logic [2:0] ST_P2   = 3'd3;
  localparam logic [2:0] ST_P3   = 3'd4;

  logic [2:0]  state;
  logic [1:0]  quad;
  logic [16:0] z;
  logic [16:0] z2;
  logic [16:0] w;
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [33:0] prod;
  logic [17:0] mag;
  logic [15:0] mag_sat;

  always_comb begin
    unique case (state)
      ST_SQ:   begin mul_a = z;         mul_b = z;  end
      ST_P1:   begin mul_a = 17'd4639;  mul_b = z2; end
      ST_P2:   begin mul_a = w;         mul_b = z2; end
      ST_P3:   begin mul_a = w;         mul_b = z;  end
      default: begin mul_a = '0;        mul_b = '0; end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign mag     = (prod[33:16] + 18'd1) >> 1;
  assign mag_sat = (mag > 18'd32767) ? 16'd32767 : mag[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_P3);
      unique case (state)
        ST_IDLE: if (start) state <= ST_SQ;
        ST_SQ:   state <= ST_P1;
        ST_P1:   state <= ST_P2;
        ST_P2:   state <= ST_P3;
        ST_P3:   state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Odd quadrants mirror the fraction; the upper half turn flips the sign.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        quad <= phase[31:30];
        z    <= phase[30] ? 17'h10000 - {1'b0, phase[29:14]} : {1'b0, phase[29:14]};
      end
      ST_SQ: z2 <= prod[32:16];
      ST_P1: w  <= 17'd42047 - prod[32:16];
      ST_P2: w  <= 17'd102944 - prod[32:16];
      ST_P3: value <= quad[1] ? -$signed(mag_sat) : $signed(mag_sat);
      default: ;
    endcase
  end

endmodule

FILE: rtl/lspt_back.sv
module lspt_back
  import lspt_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  cfg_t                         cfg,
  input  logic                         q_valid,
  input  item_t                        q_item,
  output logic                         q_pop,
  input  logic                         pop,
  output logic                         empty,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SINE = 2'd1;
  localparam logic [1:0] ST_ROT  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Coefficient slots: cosine then sine of beam, yaw, roll, pitch.
  localparam logic [2:0] CB = 3'd0;
  localparam logic [2:0] SB = 3'd1;
  localparam logic [2:0] CY = 3'd2;
  localparam logic [2:0] SY = 3'd3;
  localparam logic [2:0] CR = 3'd4;
  localparam logic [2:0] SR = 3'd5;
  localparam logic [2:0] CP = 3'd6;
  localparam logic [2:0] SP = 3'd7;

  logic [1:0]                state;
  logic [2:0]                k;
  logic [3:0]                step;
  logic                      sine_start;
  logic                      sine_done;
  logic signed [COEF_W-1:0]  sine_val;
  logic [ANGLE_BITS-1:0]     sine_angle;
  logic [31:0]               sine_phase;
  logic [RANGE_BITS-1:0]     rng;
  logic [ANGLE_BITS-1:0]     beam;
  logic signed [COEF_W-1:0]  coef [8];
  logic [2:0]                coef_sel;
  logic                      use_r;
  logic [1:0]                coord_sel;
  logic signed [COEF_W-1:0]  mul_c;
  logic signed [CW-1:0]      mul_v;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   sum_add;
  logic signed [ACC_W-1:0]   sum_sub;
  logic signed [CW-1:0]      x;
  logic signed [CW-1:0]      y;
  logic signed [CW-1:0]      z;
  logic signed [CW-1:0]      tx;
  logic                      out_valid;
  logic                      out_free;

  function automatic logic signed [COORD_BITS-1:0] finish(
    input logic signed [CW-1:0]       v,
    input logic signed [OFFSET_W-1:0] off
  );
    logic signed [FW-1:0] s;
    logic signed [FW-1:0] hi;
    logic signed [FW-1:0] lo;
    hi = $signed(FW'((64'd1 << (COORD_BITS - 1)) - 64'd1));
    lo = -hi - $signed(FW'(1));
    s  = ($signed(FW'(v)) + $signed(FW'(16384))) >>> 15;
    s  = s + $signed(FW'(off));
    if (s > hi) begin
      finish = hi[COORD_BITS-1:0];
    end else if (s < lo) begin
      finish = lo[COORD_BITS-1:0];
    end else begin
      finish = s[COORD_BITS-1:0];
    end
  endfunction

  lspt_sine u_sine (
    .clk   (clk),
    .rst   (rst),
    .start (sine_start),
    .phase (sine_phase),
    .done  (sine_done),
    .value (sine_val)
  );

  always_comb begin
    unique case (k[2:1])
      2'd0:    sine_angle = beam;
      2'd1:    sine_angle = cfg.yaw_angle;
      2'd2:    sine_angle = cfg.roll_angle;
      default: sine_angle = cfg.pitch_angle;
    endcase
  end

  // Cosine is the sine a quarter turn ahead.
  assign sine_phase = angle_phase(sine_angle) + (k[0] ? 32'd0 : 32'h4000_0000);

  always_comb begin
    use_r     = 1'b0;
    coord_sel = 2'd0;
    unique case (step)
      4'd0:    begin coef_sel = CB; use_r = 1'b1;  end
      4'd1:    begin coef_sel = SB; use_r = 1'b1;  end
      4'd2:    begin coef_sel = CY; coord_sel = 2'd0; end
      4'd3:    begin coef_sel = SY; coord_sel = 2'd1; end
      4'd4:    begin coef_sel = SY; coord_sel = 2'd0; end
      4'd5:    begin coef_sel = CY; coord_sel = 2'd1; end
      4'd6:    begin coef_sel = CR; coord_sel = 2'd0; end
      4'd7:    begin coef_sel = SR; coord_sel = 2'd2; end
      4'd8:    begin coef_sel = CR; coord_sel = 2'd2; end
      4'd9:    begin coef_sel = SR; coord_sel = 2'd0; end
      4'd10:   begin coef_sel = CP; coord_sel = 2'd0; end
      4'd11:   begin coef_sel = SP; coord_sel = 2'd1; end
      4'd12:   begin coef_sel = SP; coord_sel = 2'd0; end
      default: begin coef_sel = CP; coord_sel = 2'd1; end
    endcase
  end

  always_comb begin
    unique case (coord_sel)
      2'd0:    mul_v = x;
      2'd1:    mul_v = y;
      default: mul_v = z;
    endcase
    if (use_r) begin
      mul_v = $signed(CW'(rng));
    end
  end

  assign mul_c   = coef[coef_sel];
  assign prod    = mul_c * mul_v;
  assign sum_add = acc + ACC_W'(prod);
  assign sum_sub = acc - ACC_W'(prod);

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      k          <= '0;
      step       <= '0;
      sine_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      sine_start <= ((state == ST_IDLE) && q_valid) ||
                    ((state == ST_SINE) && sine_done && (k != SP));
      out_valid  <= (out_valid && !pop) || ((state == ST_DONE) && out_free);
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_SINE;
            k     <= '0;
          end
        end
        ST_SINE: begin
          if (sine_done) begin
            if (k == SP) begin
              state <= ST_ROT;
              step  <= '0;
            end else begin
              k <= k + 1'b1;
            end
          end
        end
        ST_ROT: begin
          step <= step + 1'b1;
          if (step == 4'd13) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rng  <= q_item.range;
      beam <= q_item.angle;
    end
    if (state == ST_SINE && sine_done) begin
      coef[k] <= sine_val;
    end
    if (state == ST_ROT) begin
      unique case (step)
        4'd0: x <= CW'(prod);
        4'd1: begin
          y <= CW'(prod);
          z <= '0;
        end
        4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12: acc <= ACC_W'(prod);
        4'd3:  tx <= CW'(round_q15(sum_sub));
        4'd5: begin
          y <= CW'(round_q15(sum_add));
          x <= tx;
        end
        4'd7:  tx <= CW'(round_q15(sum_add));
        4'd9: begin
          z <= CW'(round_q15(sum_sub));
          x <= tx;
        end
        4'd11: tx <= CW'(round_q15(sum_sub));
        4'd13: begin
          y <= CW'(round_q15(sum_add));
          x <= tx;
        end
        default: ;
      endcase
    end
    if (state == ST_DONE && out_free) begin
      point_x <= finish(x, $signed(cfg.offset_xyz[15:0]));
      point_y <= finish(y, $signed(cfg.offset_xyz[31:16]));
      point_z <= finish(z, $signed(cfg.offset_xyz[47:32]));
    end
  end

endmodule

FILE: rtl/laser_scan_point_transform.sv
// Laser scan point transform.
// Input words carry one range sample (range_mm) and a scan_start flag. A word
// is taken when push is high and full is low. scan_start reloads the beam
// angle from angle_start; any other word advances it by angle_step. Samples
// outside [range_floor, range_ceiling] advance the angle but give no result.
// Kept samples become a point that is rotated by yaw, roll and pitch, offset
// and saturated, and is shown on point_x/y/z while empty is low; pop takes it.
// Configuration is written through cfg_write, cfg_index and cfg_data, one
// register per cycle. The user must write it only while the block is idle;
// the block itself does not enforce this. For each kept sample the back end
// runs eight sine evaluations on one shared sine unit and then fourteen steps
// on one shared multiplier, and takes the next sample only once it is done. A
// two-word queue sits between the front and back ends, and the result
// register holds one finished point. When pop is held low the result stays;
// the back end waits with its next point, and once the queue fills, full
// rises. Rejected samples are taken at one per cycle while the queue has room.
// Reset (rst, synchronous) clears the angle and the queue, marks the result empty,
// and sets all configuration registers to zero except range_ceiling, which goes to all ones.
module laser_scan_point_transform
  import lspt_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [RANGE_BITS-1:0]        range_mm,
  input  logic                         scan_start,
  output logic                         empty,
  input  logic                         pop,
  output logic signed [COORD_BITS-1:0] point_x,
  output logic signed [COORD_BITS-1:0] point_y,
  output logic signed [COORD_BITS-1:0] point_z,
  input  logic                         cfg_write,
  input  logic [CFG_INDEX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  cfg_t  cfg;
  logic  q_push;
  item_t q_wr_item;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  item_t q_rd_item;

  assign full = q_full;

  lspt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .range_mm   (range_mm),
    .scan_start (scan_start),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .cfg        (cfg),
    .q_push     (q_push),
    .q_item     (q_wr_item)
  );

  lspt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .rd      (q_pop),
    .valid   (q_valid),
    .rd_item (q_rd_item)
  );

  lspt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_item  (q_rd_item),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .point_x (point_x),
    .point_y (point_y),
    .point_z (point_z)
  );

endmodule

FILE: rtl/lspt_checker.sv
module lspt_checker
  import lspt_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic signed [COORD_BITS-1:0] point_x,
  input logic signed [COORD_BITS-1:0] point_y,
  input logic signed [COORD_BITS-1:0] point_z
);

  // After reset there is nothing queued and no point waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("block not empty after reset");

  // The queue can only fill on a cycle that took a word.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without an accepted word");

  // The flow-control outputs are always known once out of reset.
  a_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown({full, empty}))
    else $error("full or empty unknown");

  // A waiting point holds until it is popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(point_x) && $stable(point_y) && $stable(point_z))
    else $error("waiting point changed or vanished");

endmodule

bind laser_scan_point_transform lspt_checker u_lspt_checker (
  .clk     (clk),
  .rst     (rst),
  .push    (push),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .point_x (point_x),
  .point_y (point_y),
  .point_z (point_z)
);
